@@ rtl/grouped_fifo_team_queue_defines.svh @@
// Assertion macros for the team queue.
// Used by the top level; needs clk and rst in scope.
`ifndef GROUPED_FIFO_TEAM_QUEUE_DEFINES_SVH
`define GROUPED_FIFO_TEAM_QUEUE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define GFTQ_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define GFTQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define GFTQ_ASSERT(lbl, ante, cons, msg)
`define GFTQ_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ rtl/gftq_pkg.sv @@
// Shared types, codes and helpers for the team queue.
// No dependencies.
package gftq_pkg;

  localparam int MEMBER_W = 10;
  localparam int TEAM_W = 5;
  localparam int STATUS_W = 2;

  localparam int DEF_NUM_MEMBERS = 1024;
  localparam int DEF_NUM_TEAMS = 32;
  localparam int DEF_CAPACITY = 256;

  localparam int RECIP_SHIFT = 2 * MEMBER_W;

  typedef enum logic [1:0] {
    MODE_ASSIGN = 2'd0,
    MODE_ENQ = 2'd1,
    MODE_DEQ = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_t;

  localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

  typedef struct packed {
    mode_t mode;
    logic [MEMBER_W-1:0] member;
    logic [TEAM_W-1:0] team;
  } cmd_t;

  typedef struct packed {
    logic [MEMBER_W-1:0] member;
    logic [STATUS_W-1:0] status;
  } res_t;

  // reciprocal multiply, then one correction step
  function automatic logic [MEMBER_W-1:0] reduce_mod(input logic [MEMBER_W-1:0] x,
                                                     input int unsigned m,
                                                     input int unsigned recip);
    logic [31:0] xw;
    logic [31:0] q;
    logic [31:0] r;
    xw = {{(32-MEMBER_W){1'b0}}, x};
    q = (xw * recip) >> RECIP_SHIFT;
    r = xw - q * m;
    if (r >= m) begin
      r = r - m;
    end
    return r[MEMBER_W-1:0];
  endfunction

endpackage

@@ rtl/gftq_front.sv @@
// Front end: accepts items, reduces member and team numbers, queues commands.
// Depends on gftq_pkg.
module gftq_front import gftq_pkg::*; #(
  parameter int NUM_MEMBERS = DEF_NUM_MEMBERS,
  parameter int NUM_TEAMS = DEF_NUM_TEAMS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic [1:0]          mode,
  input  logic [MEMBER_W-1:0] member,
  input  logic [TEAM_W-1:0]   team,
  input  logic                hold,
  output logic                cmd_valid,
  output cmd_t                cmd,
  input  logic                cmd_ready
);

  localparam int unsigned MEM_RECIP = (1 << RECIP_SHIFT) / NUM_MEMBERS;
  localparam int unsigned TEAM_RECIP = (1 << RECIP_SHIFT) / NUM_TEAMS;

  logic [1:0] count;
  logic wp;
  logic rp;
  cmd_t q [2];
  cmd_t new_cmd;
  logic [MEMBER_W-1:0] team_red;
  logic in_acc;
  logic out_acc;

  assign full = (count == 2'd2) || hold;
  assign in_acc = push && !full;
  assign cmd_valid = (count != 2'd0);
  assign out_acc = cmd_valid && cmd_ready;
  assign cmd = q[rp];

  always_comb begin
    team_red = reduce_mod({{(MEMBER_W-TEAM_W){1'b0}}, team}, NUM_TEAMS, TEAM_RECIP);
    new_cmd.mode = mode_t'(mode);
    new_cmd.member = reduce_mod(member, NUM_MEMBERS, MEM_RECIP);
    new_cmd.team = team_red[TEAM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
      wp <= 1'b0;
      rp <= 1'b0;
    end else begin
      if (in_acc) begin
        wp <= ~wp;
      end
      if (out_acc) begin
        rp <= ~rp;
      end
      count <= count + {1'b0, in_acc} - {1'b0, out_acc};
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      q[wp] <= new_cmd;
    end
  end

endmodule

@@ rtl/gftq_back.sv @@
// Back end: team table, linked-list slot storage, free stack and active ring.
// Depends on gftq_pkg.
module gftq_back import gftq_pkg::*; #(
  parameter int NUM_MEMBERS = DEF_NUM_MEMBERS,
  parameter int NUM_TEAMS = DEF_NUM_TEAMS,
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  input  cmd_t cmd,
  output logic cmd_ready,
  input  logic res_room,
  output logic res_valid,
  output res_t res,
  output logic clearing
);

  localparam int MW = $clog2(NUM_MEMBERS);
  localparam int TW = $clog2(NUM_TEAMS);
  localparam int CW = $clog2(CAPACITY);

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_ENQ_B, S_ENQ_C, S_DEQ_B, S_DEQ_C, S_DEQ_D
  } state_t;

  state_t state;
  logic [MW-1:0] init_addr;
  cmd_t cur;
  logic [CW:0] fc;
  logic [CW:0] minfc;
  logic fresh;
  logic last;
  logic [TW-1:0] front;
  logic [TW:0] count;
  logic [NUM_TEAMS-1:0] busy;
  logic [TW-1:0] t_r;
  logic [CW-1:0] s_r;

  logic [TW-1:0] tom [NUM_MEMBERS];
  logic [CW-1:0] fs [CAPACITY];
  logic [MEMBER_W-1:0] sm [CAPACITY];
  logic [CW-1:0] sn [CAPACITY];
  logic [CW-1:0] head [NUM_TEAMS];
  logic [CW-1:0] tail [NUM_TEAMS];
  logic [TW-1:0] ring [NUM_TEAMS];

  logic tom_we, fs_we, sm_we, sn_we, head_we, tail_we, ring_we;
  logic [MW-1:0] tom_wa, tom_ra;
  logic [TW-1:0] tom_wd, tom_rd;
  logic [CW-1:0] fs_wa, fs_ra, fs_wd, fs_rd;
  logic [CW-1:0] sm_wa, sm_ra;
  logic [MEMBER_W-1:0] sm_wd, sm_rd;
  logic [CW-1:0] sn_wa, sn_ra, sn_wd, sn_rd;
  logic [TW-1:0] head_wa, head_ra, tail_wa, tail_ra;
  logic [CW-1:0] head_wd, head_rd, tail_wd, tail_rd;
  logic [TW-1:0] ring_wa, ring_ra, ring_wd, ring_rd;

  logic take;
  logic [CW:0] fc_dec;
  logic [CW-1:0] enq_slot;
  logic [TW:0] ring_sum;

  assign take = (state == S_IDLE) && cmd_valid && res_room;
  assign cmd_ready = take;
  assign clearing = (state == S_INIT);
  assign fc_dec = fc - (CW+1)'(1);
  assign enq_slot = fresh ? fc[CW-1:0] : fs_rd;
  assign ring_sum = {1'b0, front} + count;

  always_comb begin
    tom_we = 1'b0;
    tom_wa = MW'(cmd.member);
    tom_wd = TW'(cmd.team);
    tom_ra = MW'(cmd.member);
    fs_we = 1'b0;
    fs_wa = fc[CW-1:0];
    fs_wd = head_rd;
    fs_ra = fc_dec[CW-1:0];
    sm_we = 1'b0;
    sm_wa = enq_slot;
    sm_wd = cur.member;
    sm_ra = head_rd;
    sn_we = 1'b0;
    sn_wa = tail_rd;
    sn_wd = s_r;
    sn_ra = head_rd;
    head_we = 1'b0;
    head_wa = tom_rd;
    head_wd = enq_slot;
    head_ra = ring_rd;
    tail_we = 1'b0;
    tail_wa = tom_rd;
    tail_wd = enq_slot;
    tail_ra = (state == S_ENQ_B) ? tom_rd : ring_rd;
    ring_we = 1'b0;
    ring_wd = tom_rd;
    ring_ra = front;
    if (ring_sum >= (TW+1)'(NUM_TEAMS)) begin
      ring_wa = TW'(ring_sum - (TW+1)'(NUM_TEAMS));
    end else begin
      ring_wa = TW'(ring_sum);
    end
    case (state)
      S_INIT: begin
        tom_we = 1'b1;
        tom_wa = init_addr;
        tom_wd = '0;
      end
      S_IDLE: begin
        tom_we = take && (cmd.mode == MODE_ASSIGN);
      end
      S_ENQ_B: begin
        sm_we = 1'b1;
        if (!busy[tom_rd]) begin
          head_we = 1'b1;
          tail_we = 1'b1;
          ring_we = 1'b1;
        end
      end
      S_ENQ_C: begin
        sn_we = 1'b1;
        tail_we = 1'b1;
        tail_wa = t_r;
        tail_wd = s_r;
      end
      S_DEQ_C: begin
        fs_we = (fc < (CW+1)'(CAPACITY));
      end
      S_DEQ_D: begin
        head_we = !last;
        head_wa = t_r;
        head_wd = sn_rd;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (tom_we) begin
      tom[tom_wa] <= tom_wd;
    end
    tom_rd <= tom[tom_ra];
  end

  always_ff @(posedge clk) begin
    if (fs_we) begin
      fs[fs_wa] <= fs_wd;
    end
    fs_rd <= fs[fs_ra];
  end

  always_ff @(posedge clk) begin
    if (sm_we) begin
      sm[sm_wa] <= sm_wd;
    end
    sm_rd <= sm[sm_ra];
  end

  always_ff @(posedge clk) begin
    if (sn_we) begin
      sn[sn_wa] <= sn_wd;
    end
    sn_rd <= sn[sn_ra];
  end

  always_ff @(posedge clk) begin
    if (head_we) begin
      head[head_wa] <= head_wd;
    end
    head_rd <= head[head_ra];
  end

  always_ff @(posedge clk) begin
    if (tail_we) begin
      tail[tail_wa] <= tail_wd;
    end
    tail_rd <= tail[tail_ra];
  end

  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring[ring_wa] <= ring_wd;
    end
    ring_rd <= ring[ring_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      init_addr <= '0;
      fc <= (CW+1)'(CAPACITY);
      minfc <= (CW+1)'(CAPACITY);
      front <= '0;
      count <= '0;
      busy <= '0;
      res_valid <= 1'b0;
    end else begin
      res_valid <= 1'b0;
      case (state)
        S_INIT: begin
          init_addr <= init_addr + MW'(1);
          if (init_addr == MW'(NUM_MEMBERS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (take) begin
            cur <= cmd;
            res.member <= '0;
            res.status <= STATUS_OK;
            case (cmd.mode)
              MODE_ASSIGN: begin
                res_valid <= 1'b1;
              end
              MODE_CLEAR: begin
                fc <= (CW+1)'(CAPACITY);
                minfc <= (CW+1)'(CAPACITY);
                front <= '0;
                count <= '0;
                busy <= '0;
                res_valid <= 1'b1;
              end
              MODE_ENQ: begin
                if (fc == '0) begin
                  res.status <= STATUS_FULL;
                  res_valid <= 1'b1;
                end else begin
                  fresh <= (fc == minfc);
                  if (fc == minfc) begin
                    minfc <= fc_dec;
                  end
                  fc <= fc_dec;
                  state <= S_ENQ_B;
                end
              end
              MODE_DEQ: begin
                if (count == '0) begin
                  res.status <= STATUS_EMPTY;
                  res_valid <= 1'b1;
                end else begin
                  state <= S_DEQ_B;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_ENQ_B: begin
          if (!busy[tom_rd]) begin
            busy[tom_rd] <= 1'b1;
            count <= count + (TW+1)'(1);
            res_valid <= 1'b1;
            state <= S_IDLE;
          end else begin
            t_r <= tom_rd;
            s_r <= enq_slot;
            state <= S_ENQ_C;
          end
        end
        S_ENQ_C: begin
          res_valid <= 1'b1;
          state <= S_IDLE;
        end
        S_DEQ_B: begin
          t_r <= ring_rd;
          state <= S_DEQ_C;
        end
        S_DEQ_C: begin
          if (fc < (CW+1)'(CAPACITY)) begin
            fc <= fc + (CW+1)'(1);
          end
          if (head_rd == tail_rd) begin
            busy[t_r] <= 1'b0;
            front <= (front == TW'(NUM_TEAMS - 1)) ? '0 : front + TW'(1);
            count <= count - (TW+1)'(1);
            last <= 1'b1;
          end else begin
            last <= 1'b0;
          end
          state <= S_DEQ_D;
        end
        S_DEQ_D: begin
          res.member <= sm_rd;
          res_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/gftq_rq.sv @@
// Result queue: two-entry buffer between the back end and the result ports.
// Depends on gftq_pkg.
module gftq_rq import gftq_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                res_valid,
  input  res_t                res,
  output logic                room,
  output logic                empty,
  input  logic                pop,
  output logic [MEMBER_W-1:0] member_out,
  output logic [STATUS_W-1:0] status
);

  logic [1:0] count;
  logic wp;
  logic rp;
  res_t q [2];
  logic out_acc;

  assign room = (count == 2'd0) || ((count == 2'd1) && !res_valid);
  assign empty = (count == 2'd0);
  assign out_acc = pop && !empty;
  assign member_out = q[rp].member;
  assign status = q[rp].status;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
      wp <= 1'b0;
      rp <= 1'b0;
    end else begin
      if (res_valid) begin
        wp <= ~wp;
      end
      if (out_acc) begin
        rp <= ~rp;
      end
      count <= count + {1'b0, res_valid} - {1'b0, out_acc};
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      q[wp] <= res;
    end
  end

endmodule

@@ rtl/grouped_fifo_team_queue.sv @@
// Top level of the team queue: front end, back end and result queue.
// Depends on gftq_pkg, gftq_front, gftq_back, gftq_rq and the defines header.
//
// Input channel: drive mode, member, team and push; the item is taken at a
// clock edge with push high and full low. Every item gives exactly one result.
// Result channel: while empty is low, member_out and status hold the oldest
// result; it is taken at a clock edge with pop high.
// In the back end an assign, clear or rejected item is handled in S_IDLE
// alone, an enqueue also passes S_ENQ_B (and S_ENQ_C when the team already
// waits), a dequeue S_DEQ_B, S_DEQ_C and S_DEQ_D; the chain of registered
// reads through the linked-list memories sets this.
// Reset: after rst falls, full stays high for NUM_MEMBERS cycles while the
// member-to-team table is swept to team 0.
// When the receiver stalls, two results wait in the result queue, the back
// end then holds, and two more items wait in the command queue before full.
`include "grouped_fifo_team_queue_defines.svh"
module grouped_fifo_team_queue import gftq_pkg::*; #(
  parameter int NUM_MEMBERS = DEF_NUM_MEMBERS,
  parameter int NUM_TEAMS = DEF_NUM_TEAMS,
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic [1:0]          mode,
  input  logic [MEMBER_W-1:0] member,
  input  logic [TEAM_W-1:0]   team,
  output logic                empty,
  input  logic                pop,
  output logic [MEMBER_W-1:0] member_out,
  output logic [STATUS_W-1:0] status
);

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;
  logic res_valid;
  res_t res;
  logic rq_room;
  logic clearing;

  gftq_front #(
    .NUM_MEMBERS(NUM_MEMBERS),
    .NUM_TEAMS(NUM_TEAMS)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .mode(mode),
    .member(member),
    .team(team),
    .hold(clearing),
    .cmd_valid(cmd_valid),
    .cmd(cmd),
    .cmd_ready(cmd_ready)
  );

  gftq_back #(
    .NUM_MEMBERS(NUM_MEMBERS),
    .NUM_TEAMS(NUM_TEAMS),
    .CAPACITY(CAPACITY)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd(cmd),
    .cmd_ready(cmd_ready),
    .res_room(rq_room),
    .res_valid(res_valid),
    .res(res),
    .clearing(clearing)
  );

  gftq_rq u_rq (
    .clk(clk),
    .rst(rst),
    .res_valid(res_valid),
    .res(res),
    .room(rq_room),
    .empty(empty),
    .pop(pop),
    .member_out(member_out),
    .status(status)
  );

  `GFTQ_ASSERT(a_err_no_member, !empty && status != STATUS_OK, member_out == '0, "error result carries a member")
  `GFTQ_ASSERT(a_sweep_blocks, clearing, full, "item accepted during table sweep")
  `GFTQ_ASSERT_NEXT(a_res_lands, res_valid, !empty, "result dropped by result queue")
  `GFTQ_ASSERT_NEXT(a_sweep_once, !clearing, !clearing, "table sweep restarted")

endmodule

@@ sim/grouped_fifo_team_queue_test.sv @@
// Testbench for the team queue: directed and random items on the input
// queue, each result checked against a behavioral team queue model.
// Depends on gftq_pkg and the grouped_fifo_team_queue RTL.
`timescale 1ns / 100ps
module grouped_fifo_team_queue_test;
  import gftq_pkg::*;

  localparam int N_MEM = DEF_NUM_MEMBERS;
  localparam int N_TEAM = DEF_NUM_TEAMS;
  localparam int CAP = DEF_CAPACITY;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic [1:0] mode = MODE_ASSIGN;
  logic [MEMBER_W-1:0] member = '0;
  logic [TEAM_W-1:0] team = '0;
  logic full, empty;
  logic [MEMBER_W-1:0] member_out;
  logic [STATUS_W-1:0] status;

  grouped_fifo_team_queue u_top (
    .clk(clk), .rst(rst), .push(push), .full(full), .mode(mode), .member(member),
    .team(team), .empty(empty), .pop(pop), .member_out(member_out), .status(status)
  );

  always #4 clk = ~clk;

  // model state
  logic [TEAM_W-1:0] team_tbl [N_MEM];
  logic [MEMBER_W-1:0] team_fifo [N_TEAM][$];
  logic [TEAM_W-1:0] active_teams [$];
  int stored;
  res_t expected_q [$];
  int errors = 0;
  int cycles = 0;
  bit quiet = 0;

  function automatic res_t predict_team_queue(mode_t m, logic [MEMBER_W-1:0] mb,
                                              logic [TEAM_W-1:0] tm);
    res_t r;
    logic [TEAM_W-1:0] t;
    r = '0;
    case (m)
      MODE_ASSIGN: team_tbl[mb] = tm;
      MODE_ENQ: begin
        if (stored >= CAP) begin
          r.status = STATUS_FULL;
        end else begin
          t = team_tbl[mb];
          if (team_fifo[t].size() == 0) active_teams = {active_teams, t};
          team_fifo[t] = {team_fifo[t], mb};
          stored++;
        end
      end
      MODE_DEQ: begin
        if (active_teams.size() == 0) begin
          r.status = STATUS_EMPTY;
        end else begin
          t = active_teams[0];
          r.member = team_fifo[t].pop_front();
          stored--;
          if (team_fifo[t].size() == 0) void'(active_teams.pop_front());
        end
      end
      default: begin
        for (int i = 0; i < N_TEAM; i++) team_fifo[i].delete();
        active_teams.delete();
        stored = 0;
      end
    endcase
    return r;
  endfunction

  task automatic send_item(mode_t m, logic [MEMBER_W-1:0] mb, logic [TEAM_W-1:0] tm);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    push <= 1'b1;
    mode <= m;
    member <= mb;
    team <= tm;
    @(posedge clk);
    while (full) @(posedge clk);
    expected_q = {expected_q, predict_team_queue(m, mb, tm)};
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (!rst) begin
      if (!quiet && $urandom_range(0, 5) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
      pop <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
    if (!rst && pop && !empty) begin
      if (expected_q.size() == 0) begin
        $display("%0t: result with none expected: member %0d status %0d",
                 $time, member_out, status);
        errors++;
      end else begin
        res_t e;
        e = expected_q.pop_front();
        if (e.member !== member_out) begin
          $display("%0t: member_out expected %0d actual %0d", $time, e.member, member_out);
          errors++;
        end
        if (e.status !== status) begin
          $display("%0t: status expected %0d actual %0d", $time, e.status, status);
          errors++;
        end
      end
    end
  end

  task automatic test_directed();
    send_item(MODE_DEQ, '0, '0);
    send_item(MODE_ENQ, 10'd0, '0);
    send_item(MODE_ASSIGN, 10'd1023, 5'd31);
    send_item(MODE_ASSIGN, 10'd5, 5'd31);
    send_item(MODE_ASSIGN, 10'd682, 5'd21);
    send_item(MODE_ENQ, 10'd1023, 5'd10);
    send_item(MODE_ENQ, 10'd682, '0);
    send_item(MODE_ENQ, 10'd5, '0);
    send_item(MODE_ENQ, 10'd341, '0);
    for (int i = 0; i < 6; i++) send_item(MODE_DEQ, 10'(i), 5'(i));
    send_item(MODE_ENQ, 10'd7, '0);
    send_item(MODE_CLEAR, 10'd1023, 5'd31);
    send_item(MODE_DEQ, '0, '0);
  endtask

  task automatic test_overflow();
    for (int i = 0; i < CAP + 2; i++) send_item(MODE_ENQ, 10'($urandom), 5'($urandom));
    for (int i = 0; i < 20; i++) send_item(MODE_DEQ, 10'($urandom), 5'($urandom));
    send_item(MODE_ENQ, 10'($urandom), '0);
    send_item(MODE_CLEAR, '0, '0);
  endtask

  task automatic test_random(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 15) send_item(MODE_ASSIGN, 10'($urandom_range(0, 63)), 5'($urandom));
      else if (r < 20) send_item(MODE_ASSIGN, 10'($urandom), 5'($urandom));
      else if (r < 55) send_item(MODE_ENQ, 10'($urandom_range(0, 63)), 5'($urandom));
      else if (r < 62) send_item(MODE_ENQ, 10'($urandom), 5'($urandom));
      else if (r < 99) send_item(MODE_DEQ, 10'($urandom), 5'($urandom));
      else send_item(MODE_CLEAR, 10'($urandom), 5'($urandom));
    end
  endtask

  initial begin
    for (int i = 0; i < N_MEM; i++) team_tbl[i] = '0;
    stored = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_overflow();
    test_random(1000);
    quiet = 1;
    test_random(100);
    push <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
